### rtl/core/ast_pkg.sv
// Shared types, constants and helper functions of the adaptive staircase tracker.
package ast_pkg;

  localparam int StepDepth = 16;
  localparam int HistDepth = 8;
  localparam int LevelW    = 32;

  localparam int StepIdxW  = $clog2(StepDepth);
  localparam int WinCntW   = $clog2(HistDepth + 1);
  localparam int StepW     = 31;
  localparam int CfgW      = 32;
  localparam int CfgIdxW   = 3;
  localparam int TrialW    = 10;
  localparam int RevW      = 8;
  localparam int HitW      = 8;
  localparam int FieldLvlW = 32;
  // room for level +/- one step and for the 32-bit clamp bounds
  localparam int CalcW     = ((LevelW > FieldLvlW) ? LevelW : FieldLvlW) + 2;

  typedef enum logic [1:0] {
    ActTrial      = 2'd0,
    ActLoadMulti  = 2'd1,
    ActLoadSingle = 2'd2,
    ActRestart    = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegAscending     = 3'd0,
    RegAnswersNeeded = 3'd1,
    RegMaxTrials     = 3'd2,
    RegMaxReversals  = 3'd3,
    RegClampLower    = 3'd4,
    RegClampUpper    = 3'd5,
    RegClampHitLimit = 3'd6,
    RegStartLevel    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic                        ascending;
    logic [3:0]                  answers_needed;
    logic [TrialW-1:0]           max_trials;
    logic [4:0]                  max_reversals;
    logic signed [FieldLvlW-1:0] clamp_lower;
    logic signed [FieldLvlW-1:0] clamp_upper;
    logic [HitW-1:0]             clamp_hit_limit;
    logic signed [FieldLvlW-1:0] start_level;
  } cfg_t;

  typedef struct packed {
    action_e          action;
    logic             answer;
    logic [3:0]       step_index;
    logic [StepW-1:0] step_value;
  } item_t;

  typedef struct packed {
    logic                        is_multi;
    logic [StepIdxW-1:0]         idx;
  } step_rd_t;

  typedef struct packed {
    logic signed [FieldLvlW-1:0] level;
    logic [RevW-1:0]             reversals;
    logic [TrialW-1:0]           trials_done;
    logic                        reversed_now;
    logic                        finished;
  } result_t;

  localparam logic signed [CalcW-1:0] LvlMax = {{(CalcW - LevelW + 1){1'b0}},
                                                {(LevelW - 1){1'b1}}};
  localparam logic signed [CalcW-1:0] LvlMin = ~LvlMax;

  function automatic logic signed [LevelW-1:0] sat_level(input logic signed [CalcW-1:0] v);
    logic signed [CalcW-1:0] r;
    if (v > LvlMax) begin
      r = LvlMax;
    end else if (v < LvlMin) begin
      r = LvlMin;
    end else begin
      r = v;
    end
    return r[LevelW-1:0];
  endfunction

  // reversals/2, capped at entry max_reversals-1 and at the table end; that entry once the reversal limit is reached
  function automatic logic [StepIdxW-1:0] tab_index(input logic [RevW-1:0] rev,
                                                    input logic [4:0]      max_rev);
    logic [4:0]      mr;
    logic [RevW-1:0] lim;
    logic [RevW-1:0] i;
    mr  = (max_rev == '0) ? 5'd1 : max_rev;
    lim = RevW'(mr - 5'd1);
    i   = (rev == RevW'(mr)) ? lim : (rev >> 1);
    if (i > lim) i = lim;
    if (32'(i) > StepDepth - 1) i = RevW'(StepDepth - 1);
    return StepIdxW'(i);
  endfunction

endpackage

### rtl/core/ast_if.sv
// Valid/ready channel interfaces for input and result words.
interface ast_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                action;
  logic                      answer;
  logic [3:0]                step_index;
  logic [ast_pkg::StepW-1:0] step_value;

  modport source(output valid, action, answer, step_index, step_value, input ready);
  modport sink(input valid, action, answer, step_index, step_value, output ready);
endinterface

interface ast_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ast_pkg::FieldLvlW-1:0] level;
  logic [ast_pkg::RevW-1:0]             reversals;
  logic [ast_pkg::TrialW-1:0]           trials_done;
  logic                                 reversed_now;
  logic                                 finished;

  modport source(output valid, level, reversals, trials_done, reversed_now, finished,
                 input ready);
  modport sink(input valid, level, reversals, trials_done, reversed_now, finished,
               output ready);
endinterface

### rtl/core/ast_step_tables.sv
// Host-loaded single-answer and multi-answer step tables.
module ast_step_tables (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic                      wr_multi_i,
  input  logic [3:0]                wr_index_i,
  input  logic [ast_pkg::StepW-1:0] wr_value_i,
  input  ast_pkg::step_rd_t         rd_i,
  output logic [ast_pkg::StepW-1:0] rd_value_o
);
  import ast_pkg::*;

  logic [StepW-1:0] multi_q  [StepDepth];
  logic [StepW-1:0] single_q [StepDepth];

  // an index past the table end is dropped
  always_ff @(posedge clk_i) begin
    for (int e = 0; e < StepDepth; e++) begin
      if (we_i && (32'(wr_index_i) == e)) begin
        if (wr_multi_i) begin
          multi_q[e] <= wr_value_i;
        end else begin
          single_q[e] <= wr_value_i;
        end
      end
    end
  end

  assign rd_value_o = rd_i.is_multi ? multi_q[rd_i.idx] : single_q[rd_i.idx];

endmodule

### rtl/core/ast_trial_unit.sv
// Tracker state and the combinational trial / restart update.
module ast_trial_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  ast_pkg::item_t            item_i,
  input  ast_pkg::cfg_t             cfg_i,
  output ast_pkg::step_rd_t         step_rd_o,
  input  logic [ast_pkg::StepW-1:0] step_val_i,
  output ast_pkg::result_t          result_o
);
  import ast_pkg::*;

  logic signed [LevelW-1:0] level_q, level_d;
  logic                     dir_q, dir_d;
  logic [RevW-1:0]          rev_q, rev_d;
  logic [TrialW-1:0]        trial_q, trial_d;
  logic [HistDepth-1:0]     hist_q, hist_d;
  logic [HitW-1:0]          uhits_q, uhits_d;
  logic [HitW-1:0]          lhits_q, lhits_d;

  logic [WinCntW-1:0]       n_eff;
  logic [HistDepth-1:0]     win;
  logic [TrialW-1:0]        trial_n;
  logic                     dir0;
  logic [HistDepth-1:0]     hist_sh, hx;
  logic                     asc, ans;
  logic                     single, multi, do_turn, target, turned;
  logic [RevW-1:0]          rev_n;
  logic signed [CalcW-1:0]  step_ext, level_ext, lvl_raw, lo, hi, lvl_cl;
  logic                     above, below;
  logic signed [CalcW-1:0]  level_out;

  assign asc = cfg_i.ascending;
  assign ans = item_i.answer;

  always_comb begin
    if (cfg_i.answers_needed == '0) begin
      n_eff = WinCntW'(1);
    end else if (32'(cfg_i.answers_needed) > HistDepth) begin
      n_eff = WinCntW'(HistDepth);
    end else begin
      n_eff = WinCntW'(cfg_i.answers_needed);
    end
    for (int b = 0; b < HistDepth; b++) begin
      win[b] = (32'(n_eff) > b);
    end
  end

  // trial path: at most one table step per trial
  always_comb begin
    trial_n = (trial_q == '1) ? trial_q : trial_q + 1'b1;
    dir0    = (trial_n == TrialW'(1)) ? ans : dir_q;
    hist_sh = HistDepth'({hist_q, ans});
    hx      = asc ? hist_sh : ~hist_sh;
    single  = (asc == ans);
    multi   = !single && ((rev_q == '0) ||
                          (((hx & win) == '0) && (trial_n > TrialW'(1))));
    do_turn = single || multi;
    target  = single ? asc : !asc;
    turned  = do_turn && (dir0 != target);
    rev_n   = (turned && (rev_q != '1)) ? rev_q + 1'b1 : rev_q;

    step_rd_o.is_multi = multi;
    step_rd_o.idx      = (multi && (rev_q == '0)) ? '0
                                                  : tab_index(rev_n, cfg_i.max_reversals);

    step_ext  = do_turn ? $signed(CalcW'(step_val_i)) : '0;
    level_ext = CalcW'(level_q);
    lvl_raw   = (asc ^ multi) ? level_ext - step_ext : level_ext + step_ext;
    lo        = CalcW'(cfg_i.clamp_lower);
    hi        = CalcW'(cfg_i.clamp_upper);
    above     = lvl_raw > hi;
    below     = lvl_raw < lo;
    lvl_cl    = below ? lo : (above ? hi : lvl_raw);
  end

  always_comb begin
    level_d = level_q;
    dir_d   = dir_q;
    rev_d   = rev_q;
    trial_d = trial_q;
    hist_d  = hist_q;
    uhits_d = uhits_q;
    lhits_d = lhits_q;
    unique case (item_i.action)
      ActTrial: begin
        level_d = sat_level(lvl_cl);
        dir_d   = do_turn ? target : dir0;
        rev_d   = rev_n;
        trial_d = trial_n;
        hist_d  = multi ? {HistDepth{asc}} : hist_sh;
        if (above && (uhits_q != '1)) uhits_d = uhits_q + 1'b1;
        if (below && (lhits_q != '1)) lhits_d = lhits_q + 1'b1;
      end
      ActRestart: begin
        level_d = sat_level(CalcW'(cfg_i.start_level));
        hist_d  = {HistDepth{asc}};
      end
      ActLoadMulti, ActLoadSingle: begin
      end
      default: begin
      end
    endcase
  end

  assign level_out = CalcW'(level_d);

  always_comb begin
    result_o.level        = level_out[FieldLvlW-1:0];
    result_o.reversals    = rev_d;
    result_o.trials_done  = trial_d;
    result_o.reversed_now = (item_i.action == ActTrial) && turned;
    result_o.finished     = (trial_d >= cfg_i.max_trials) ||
                            (rev_d >= RevW'(cfg_i.max_reversals)) ||
                            (uhits_d >= cfg_i.clamp_hit_limit) ||
                            (lhits_d >= cfg_i.clamp_hit_limit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      dir_q   <= 1'b1;
      rev_q   <= '0;
      trial_q <= '0;
      hist_q  <= '1;
      uhits_q <= '0;
      lhits_q <= '0;
    end else if (en_i) begin
      level_q <= level_d;
      dir_q   <= dir_d;
      rev_q   <= rev_d;
      trial_q <= trial_d;
      hist_q  <= hist_d;
      uhits_q <= uhits_d;
      lhits_q <= lhits_d;
    end
  end

endmodule

### rtl/core/adaptive_staircase_tracker_unit.sv
// Top level of the adaptive staircase tracker.
// Each accepted input word is registered, and its result word is registered once the result
// register is free. Throughput: one word per cycle while the output is not stalled; the state
// update (table read, add, clamp, counter update) is combinational between the input and result registers.
// Reset (async, active low) clears level, counters and hit counts, sets the
// direction and history to ones and loads the register defaults; step tables are not cleared.
module adaptive_staircase_tracker_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ast_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ast_pkg::CfgW-1:0]    cfg_data_i,
  ast_in_if.sink                      in_i,
  ast_out_if.source                   out_o
);
  import ast_pkg::*;

  cfg_t             cfg_q;
  item_t            item_q;
  logic             inq_valid_q;
  result_t          res_q;
  logic             outq_valid_q;
  logic             advance;
  logic             in_acc;
  result_t          result;
  step_rd_t         step_rd;
  logic [StepW-1:0] step_val;

  assign advance     = inq_valid_q && (!outq_valid_q || out_o.ready);
  assign in_i.ready  = !inq_valid_q || advance;
  assign in_acc      = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ascending       <= 1'b1;
      cfg_q.answers_needed  <= 4'd3;
      cfg_q.max_trials      <= TrialW'(30);
      cfg_q.max_reversals   <= 5'd3;
      cfg_q.clamp_lower     <= {1'b1, {(FieldLvlW - 1){1'b0}}};
      cfg_q.clamp_upper     <= {1'b0, {(FieldLvlW - 1){1'b1}}};
      cfg_q.clamp_hit_limit <= HitW'(3);
      cfg_q.start_level     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegAscending:     cfg_q.ascending       <= cfg_data_i[0];
        RegAnswersNeeded: cfg_q.answers_needed  <= cfg_data_i[3:0];
        RegMaxTrials:     cfg_q.max_trials      <= cfg_data_i[TrialW-1:0];
        RegMaxReversals:  cfg_q.max_reversals   <= cfg_data_i[4:0];
        RegClampLower:    cfg_q.clamp_lower     <= $signed(cfg_data_i[FieldLvlW-1:0]);
        RegClampUpper:    cfg_q.clamp_upper     <= $signed(cfg_data_i[FieldLvlW-1:0]);
        RegClampHitLimit: cfg_q.clamp_hit_limit <= cfg_data_i[HitW-1:0];
        RegStartLevel:    cfg_q.start_level     <= $signed(cfg_data_i[FieldLvlW-1:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q  <= 1'b0;
      outq_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        inq_valid_q <= 1'b1;
      end else if (advance) begin
        inq_valid_q <= 1'b0;
      end
      if (advance) begin
        outq_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        outq_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.action     <= action_e'(in_i.action);
      item_q.answer     <= in_i.answer;
      item_q.step_index <= in_i.step_index;
      item_q.step_value <= in_i.step_value;
    end
    if (advance) begin
      res_q <= result;
    end
  end

  ast_step_tables u_tables (
    .clk_i      (clk_i),
    .we_i       (advance && ((item_q.action == ActLoadMulti) ||
                             (item_q.action == ActLoadSingle))),
    .wr_multi_i (item_q.action == ActLoadMulti),
    .wr_index_i (item_q.step_index),
    .wr_value_i (item_q.step_value),
    .rd_i       (step_rd),
    .rd_value_o (step_val)
  );

  ast_trial_unit u_trial (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .item_i     (item_q),
    .cfg_i      (cfg_q),
    .step_rd_o  (step_rd),
    .step_val_i (step_val),
    .result_o   (result)
  );

  assign out_o.valid        = outq_valid_q;
  assign out_o.level        = res_q.level;
  assign out_o.reversals    = res_q.reversals;
  assign out_o.trials_done  = res_q.trials_done;
  assign out_o.reversed_now = res_q.reversed_now;
  assign out_o.finished     = res_q.finished;

endmodule

### rtl/core/ast_checker.sv
// Port-level assertions for the staircase tracker, bound to the top level.
module ast_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic signed [ast_pkg::FieldLvlW-1:0] out_level_i,
  input logic [ast_pkg::RevW-1:0]       out_reversals_i,
  input logic [ast_pkg::TrialW-1:0]     out_trials_i,
  input logic                           out_reversed_i,
  input logic                           out_finished_i
);
  import ast_pkg::*;

  // every accepted word is checked to be followed by a valid result word
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> ##2 out_valid_i)
    else $error("no result word two cycles after input accept");

  // input only backs up when the result stage is full and stalled
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled while result stage could move");

  // a reversal word always shows a nonzero reversal count
  a_reversal_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_reversed_i |-> out_reversals_i != '0)
    else $error("reversal flagged with zero reversal count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_level_i) &&
      $stable(out_reversals_i) && $stable(out_trials_i) &&
      $stable(out_reversed_i) && $stable(out_finished_i))
    else $error("stalled result word changed");

endmodule

bind adaptive_staircase_tracker_unit ast_checker u_ast_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_level_i     (out_o.level),
  .out_reversals_i (out_o.reversals),
  .out_trials_i    (out_o.trials_done),
  .out_reversed_i  (out_o.reversed_now),
  .out_finished_i  (out_o.finished)
);
